>>> src/tun_pkg.sv
package tun_pkg;

  // fixed field widths of the channels
  localparam int IN_BITS  = 16;
  localparam int OUT_BITS = 16;
  localparam int NUM_CRD  = 9;
  // cross magnitudes are brought below 2^PRE_BITS before squaring
  localparam int PRE_BITS = 31;
  localparam int SQ_BITS  = 2 * PRE_BITS;
  localparam int SUM_BITS = SQ_BITS + 2;

  typedef logic signed [IN_BITS-1:0]  crd_t;
  typedef logic signed [OUT_BITS-1:0] nrm_t;

  // per-item sideband that rides along the arithmetic
  typedef struct packed {
    logic [2:0] neg;
    logic       degen;
  } tun_side_t;

endpackage

>>> src/tun_if.sv
interface tun_in_if import tun_pkg::*; ();
  logic valid;
  logic ready;
  crd_t a_x, a_y, a_z;
  crd_t b_x, b_y, b_z;
  crd_t c_x, c_y, c_z;

  modport source(output valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
                 input ready);
  modport sink(input valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
               output ready);
endinterface

interface tun_out_if import tun_pkg::*; ();
  logic valid;
  logic ready;
  nrm_t normal_x, normal_y, normal_z;
  logic degenerate;

  modport source(output valid, normal_x, normal_y, normal_z, degenerate,
                 input ready);
  modport sink(input valid, normal_x, normal_y, normal_z, degenerate,
               output ready);
endinterface

>>> src/triangle_unit_normal.sv
// Channel   Port     Dir  Payload
// input     in_tri   in   a_x..c_z: three vertices, signed 16-bit coordinates
// result    out_nrm  out  normal_x/y/z signed Q1.FRAC_BITS, degenerate flag
//
// The pipeline holds the edge, cross product, prescale and sum of squares
// stages, 2*FRAC_BITS + 3 divider stages, FRAC_BITS + 2 square-root stages
// and the output register. One item per cycle is accepted while out_nrm is
// not stalled. Reset clears only the valid bits.
// When a result is held on out_nrm, the whole pipeline freezes and in_tri
// ready drops; nothing is dropped or repeated.
module triangle_unit_normal import tun_pkg::*; #(
  parameter int COORD_BITS = 16,
  parameter int FRAC_BITS  = 14
) (
  input  logic     clk,
  input  logic     rst_n,
  tun_in_if.sink   in_tri,
  tun_out_if.source out_nrm
);

  localparam int K   = 2 * FRAC_BITS + 3;
  localparam int NS  = FRAC_BITS + 2;
  localparam int DL  = K + NS;
  localparam int RTW = NS;

  logic                           en;
  crd_t [NUM_CRD-1:0]             crd;
  logic                           fr_valid;
  tun_side_t                      fr_side;
  logic [SUM_BITS-1:0]            sum_sq;
  logic [2:0][SQ_BITS-2:0]        half_sq;
  logic [2:0]                     low_sq;
  logic [2:0][K-1:0]              quo;
  logic [2:0][RTW-1:0]            root;
  logic [DL-1:0]                  dv_r;
  tun_side_t                      ds_r [DL];
  logic                           out_valid_r;
  nrm_t                           nrm_r [3];
  logic                           degen_r;
  nrm_t                           nrm_c [3];

  // global advance: the output slot is free or being taken
  assign en           = !out_valid_r || out_nrm.ready;
  assign in_tri.ready = en;

  assign crd = {in_tri.c_z, in_tri.c_y, in_tri.c_x,
                in_tri.b_z, in_tri.b_y, in_tri.b_x,
                in_tri.a_z, in_tri.a_y, in_tri.a_x};

  tun_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_tri.valid),
    .crd       (crd),
    .out_valid (fr_valid),
    .out_side  (fr_side),
    .sum_sq    (sum_sq),
    .half_sq   (half_sq),
    .low_sq    (low_sq)
  );

  tun_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk     (clk),
    .en      (en),
    .sum_sq  (sum_sq),
    .half_sq (half_sq),
    .low_sq  (low_sq),
    .quo     (quo)
  );

  tun_sqrt #(.FRAC_BITS(FRAC_BITS)) u_sqrt (
    .clk  (clk),
    .en   (en),
    .rad  (quo),
    .root (root)
  );

  // valid and sideband alongside divider and square root
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_r <= '0;
    end else if (en) begin
      dv_r <= {dv_r[DL-2:0], fr_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ds_r[0] <= fr_side;
      for (int k = 1; k < DL; k++) ds_r[k] <= ds_r[k-1];
    end
  end

  // round half up, restore sign, zero on degenerate
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      logic [RTW:0] q;
      logic [31:0]  qw;
      q  = ((RTW+1)'(root[i]) + (RTW+1)'(1)) >> 1;
      qw = 32'(q);
      if (ds_r[DL-1].degen) begin
        nrm_c[i] = '0;
      end else if (ds_r[DL-1].neg[i]) begin
        nrm_c[i] = OUT_BITS'(-qw);
      end else begin
        nrm_c[i] = OUT_BITS'(qw);
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= dv_r[DL-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nrm_r   <= nrm_c;
      degen_r <= ds_r[DL-1].degen;
    end
  end

  assign out_nrm.valid      = out_valid_r;
  assign out_nrm.normal_x   = nrm_r[0];
  assign out_nrm.normal_y   = nrm_r[1];
  assign out_nrm.normal_z   = nrm_r[2];
  assign out_nrm.degenerate = degen_r;

endmodule

>>> src/tun_front.sv
module tun_front import tun_pkg::*; #(
  parameter int COORD_BITS = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic                      in_valid,
  input  crd_t [NUM_CRD-1:0]        crd,
  output logic                      out_valid,
  output tun_side_t                 out_side,
  output logic [SUM_BITS-1:0]       sum_sq,
  output logic [2:0][SQ_BITS-2:0]   half_sq,
  output logic [2:0]                low_sq
);

  localparam int DW   = COORD_BITS + 1;
  localparam int PW   = 2 * DW;
  localparam int CXW  = (COORD_BITS > IN_BITS) ? COORD_BITS : IN_BITS;
  localparam int SHW  = $clog2(PW + 1);
  localparam int NSTG = 7;

  logic [NSTG-1:0] v_r;
  tun_side_t       side_r [3:NSTG];

  logic signed [COORD_BITS-1:0] cc [NUM_CRD];
  logic signed [DW-1:0]         d_r [6];
  logic signed [PW-1:0]         p_r [6];
  logic signed [PW:0]           n_c [3];
  logic [PW-1:0]                m_r [3];
  logic [PW-1:0]                m4_r [3];
  logic [SHW-1:0]               sh_r;
  logic [PRE_BITS-1:0]          ms_r [3];
  logic [SQ_BITS-1:0]           sq_r [3];
  logic [SUM_BITS-1:0]          sum_r;
  logic [SQ_BITS-2:0]           half_r [3];
  logic [2:0]                   low_r;
  tun_side_t                    side_c;
  logic [PW-1:0]                orw;
  logic [SHW-1:0]               sh_c;

  // coordinates: low COORD_BITS bits, two's complement
  always_comb begin
    for (int k = 0; k < NUM_CRD; k++) begin
      logic [CXW-1:0] w;
      w = CXW'(unsigned'(crd[k]));
      cc[k] = w[COORD_BITS-1:0];
    end
  end

  // valid shift
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[NSTG-2:0], in_valid};
    end
  end

  // stage 1: edges
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        d_r[i]     <= DW'(cc[3+i]) - DW'(cc[i]);
        d_r[3 + i] <= DW'(cc[6+i]) - DW'(cc[i]);
      end
    end
  end

  // stage 2: partial products of the cross product
  always_ff @(posedge clk) begin
    if (en) begin
      p_r[0] <= d_r[1] * d_r[5];
      p_r[1] <= d_r[2] * d_r[4];
      p_r[2] <= d_r[2] * d_r[3];
      p_r[3] <= d_r[0] * d_r[5];
      p_r[4] <= d_r[0] * d_r[4];
      p_r[5] <= d_r[1] * d_r[3];
    end
  end

  // stage 3: cross components, sign and magnitude
  always_comb begin
    side_c.degen = 1'b1;
    for (int i = 0; i < 3; i++) begin
      n_c[i] = (PW+1)'(p_r[2*i]) - (PW+1)'(p_r[2*i+1]);
      side_c.neg[i] = n_c[i][PW];
      if (n_c[i] != '0) side_c.degen = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        m_r[i] <= n_c[i][PW] ? PW'(-n_c[i]) : PW'(n_c[i]);
      end
      side_r[3] <= side_c;
    end
  end

  // stage 4: prescale shift from the leading one of the largest magnitude
  always_comb begin
    orw  = m_r[0] | m_r[1] | m_r[2];
    sh_c = '0;
    for (int b = PRE_BITS; b < PW; b++) begin
      if (orw[b]) sh_c = SHW'(b - PRE_BITS + 1);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sh_r      <= sh_c;
      m4_r      <= m_r;
      side_r[4] <= side_r[3];
    end
  end

  // stage 5: apply the shift
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        ms_r[i] <= PRE_BITS'((PW+PRE_BITS)'(m4_r[i]) >> sh_r);
      end
      side_r[5] <= side_r[4];
    end
  end

  // stage 6: squares
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sq_r[i] <= SQ_BITS'(ms_r[i]) * SQ_BITS'(ms_r[i]);
      end
      side_r[6] <= side_r[5];
    end
  end

  // stage 7: sum of squares, divider start values
  always_ff @(posedge clk) begin
    if (en) begin
      sum_r <= SUM_BITS'(sq_r[0]) + SUM_BITS'(sq_r[1]) + SUM_BITS'(sq_r[2]);
      for (int i = 0; i < 3; i++) begin
        half_r[i] <= sq_r[i][SQ_BITS-1:1];
        low_r[i]  <= sq_r[i][0];
      end
      side_r[NSTG] <= side_r[6];
    end
  end

  assign out_valid = v_r[NSTG-1];
  assign out_side  = side_r[NSTG];
  assign sum_sq    = sum_r;
  always_comb begin
    for (int i = 0; i < 3; i++) half_sq[i] = half_r[i];
  end
  assign low_sq = low_r;

endmodule

>>> src/tun_div.sv
module tun_div import tun_pkg::*; #(
  parameter int FRAC_BITS = 14
) (
  input  logic                              clk,
  input  logic                              en,
  input  logic [SUM_BITS-1:0]               sum_sq,
  input  logic [2:0][SQ_BITS-2:0]           half_sq,
  input  logic [2:0]                        low_sq,
  output logic [2:0][2*FRAC_BITS+2:0]       quo
);

  // restoring division, one quotient bit per stage, three lanes share the divisor
  localparam int K  = 2 * FRAC_BITS + 3;
  localparam int RW = SUM_BITS;

  logic [RW-1:0] s_r   [K];
  logic [RW-1:0] rem_r [K][3];
  logic [K-1:0]  quo_r [K][3];

  for (genvar j = 0; j < K; j++) begin : g_stg
    logic [RW-1:0] s_in;
    logic [RW-1:0] rem_in [3];
    logic [K-1:0]  quo_in [3];
    logic [2:0]    bit_in;

    if (j == 0) begin : g_first
      assign s_in   = sum_sq;
      assign bit_in = low_sq;
      for (genvar i = 0; i < 3; i++) begin : g_l
        assign rem_in[i] = RW'(half_sq[i]);
        assign quo_in[i] = '0;
      end
    end else begin : g_next
      assign s_in   = s_r[j-1];
      assign bit_in = '0;
      for (genvar i = 0; i < 3; i++) begin : g_l
        assign rem_in[i] = rem_r[j-1][i];
        assign quo_in[i] = quo_r[j-1][i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        s_r[j] <= s_in;
        for (int i = 0; i < 3; i++) begin
          logic [RW:0]   shd;
          logic [RW+1:0] dif;
          shd = {rem_in[i], bit_in[i]};
          dif = {1'b0, shd} - {2'b00, s_in};
          if (!dif[RW+1]) begin
            rem_r[j][i] <= dif[RW-1:0];
          end else begin
            rem_r[j][i] <= shd[RW-1:0];
          end
          quo_r[j][i] <= {quo_in[i][K-2:0], ~dif[RW+1]};
        end
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) quo[i] = quo_r[K-1][i];
  end

endmodule

>>> src/tun_sqrt.sv
module tun_sqrt import tun_pkg::*; #(
  parameter int FRAC_BITS = 14
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic [2:0][2*FRAC_BITS+2:0]   rad,
  output logic [2:0][FRAC_BITS+1:0]     root
);

  // digit-by-digit integer square root, one root bit per stage
  localparam int NS   = FRAC_BITS + 2;
  localparam int PADW = 2 * NS;
  localparam int RSW  = FRAC_BITS + 5;
  localparam int RTW  = NS;

  logic [PADW-1:0] rad_r  [NS][3];
  logic [RSW-1:0]  rem_r  [NS][3];
  logic [RTW-1:0]  root_r [NS][3];

  for (genvar j = 0; j < NS; j++) begin : g_stg
    logic [PADW-1:0] rad_in  [3];
    logic [RSW-1:0]  rem_in  [3];
    logic [RTW-1:0]  root_in [3];

    if (j == 0) begin : g_first
      for (genvar i = 0; i < 3; i++) begin : g_l
        assign rad_in[i]  = PADW'(rad[i]);
        assign rem_in[i]  = '0;
        assign root_in[i] = '0;
      end
    end else begin : g_next
      for (genvar i = 0; i < 3; i++) begin : g_l
        assign rad_in[i]  = rad_r[j-1][i];
        assign rem_in[i]  = rem_r[j-1][i];
        assign root_in[i] = root_r[j-1][i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        for (int i = 0; i < 3; i++) begin
          logic [RSW-1:0] rsh;
          logic [RSW-1:0] trial;
          logic           ge;
          rsh   = {rem_in[i][RSW-3:0], rad_in[i][PADW-1-2*j -: 2]};
          trial = RSW'({root_in[i], 2'b01});
          ge    = (rsh >= trial);
          rad_r[j][i]  <= rad_in[i];
          rem_r[j][i]  <= ge ? (rsh - trial) : rsh;
          root_r[j][i] <= {root_in[i][RTW-2:0], ge};
        end
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) root[i] = root_r[NS-1][i];
  end

endmodule
